// ----- rtl/fapd_pkg.sv -----
// Shared types, constants and a saturation helper for the four-axis PD controller.
package fapd_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned WIDE_W = 48;

	typedef logic signed [DATA_W-1:0] q16_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic [2:0] {
		REG_YAW_P     = 3'd0,
		REG_YAW_D     = 3'd1,
		REG_LAT_P     = 3'd2,
		REG_LAT_D     = 3'd3,
		REG_FWD_P     = 3'd4,
		REG_FWD_D     = 3'd5,
		REG_FWD_BIAS  = 3'd6
	} fapd_reg_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} fapd_adv_t;

	localparam q16_t FWD_GAIN_P_RST = 32'sd2621;
	localparam q16_t FWD_GAIN_D_RST = 32'sd6554;

	localparam wide_t HEIGHT_KP = 48'sd5;
	localparam wide_t HEIGHT_KD = 48'sd30;

	// ceil(2^35 / 10): exact quotient by ten for any 32-bit magnitude
	localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;
	localparam int unsigned RECIP10_SH = 35;
	localparam int unsigned QUOT_W     = 28;

	localparam logic [17:0] VERT_LIM = 18'd131072;
	localparam q16_t        YAW_LIM  = 32'sd1310720;
	localparam q16_t        LAT_LIM  = 32'sd52429;
	localparam q16_t        FWD_LIM  = 32'sd19661;

	localparam q16_t S32_MAX = 32'sh7FFFFFFF;
	localparam q16_t S32_MIN = 32'sh80000000;

	function automatic q16_t sat48(input wide_t v);
		q16_t r;
		if (v[WIDE_W-1:DATA_W-1] == {(WIDE_W-DATA_W+1){v[DATA_W-1]}}) begin
			r = v[DATA_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = S32_MIN;
		end else begin
			r = S32_MAX;
		end
		return r;
	endfunction

endpackage

// ----- rtl/fapd_lane.sv -----
// One proportional-derivative lane with configurable gains and saturating arithmetic.
module fapd_lane import fapd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fapd_adv_t adv,
	input  logic      take,
	input  q16_t      err,
	input  q16_t      gain_p,
	input  q16_t      gain_d,
	output q16_t      pd_s3
);

	q16_t               prev_q;
	q16_t               e_s1;
	q16_t               d_s1;
	logic signed [63:0] prod_p_s2;
	logic signed [63:0] prod_d_s2;
	q16_t               term_p;
	q16_t               term_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (take) begin
			prev_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en1) begin
			e_s1 <= err;
			d_s1 <= sat48(WIDE_W'(err) - WIDE_W'(prev_q));
		end
		if (adv.en2) begin
			prod_p_s2 <= e_s1 * gain_p;
			prod_d_s2 <= d_s1 * gain_d;
		end
		if (adv.en3) begin
			pd_s3 <= sat48(WIDE_W'(term_p) + WIDE_W'(term_d));
		end
	end

	// drop 16 fraction bits, rounding toward minus infinity
	assign term_p = sat48(signed'(prod_p_s2[63:16]));
	assign term_d = sat48(signed'(prod_d_s2[63:16]));

endmodule

// ----- rtl/fapd_height.sv -----
// Height lane: fixed gains, divide by ten via reciprocal multiply.
module fapd_height import fapd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fapd_adv_t         adv,
	input  logic              take,
	input  q16_t              target,
	input  q16_t              measured,
	output logic [QUOT_W-1:0] quot_s3,
	output logic              neg_s3
);

	q16_t        prev_q;
	q16_t        eh;
	q16_t        eh_s1;
	q16_t        dh_s1;
	q16_t        h_s2;
	logic [31:0] mag;
	logic [63:0] recip_prod;

	assign eh = sat48(WIDE_W'(target) - WIDE_W'(measured));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (take) begin
			prev_q <= eh;
		end
	end

	assign mag        = h_s2[DATA_W-1] ? (~h_s2 + 32'd1) : h_s2;
	assign recip_prod = 64'(mag) * 64'(RECIP10);

	always_ff @(posedge clk) begin
		if (adv.en1) begin
			eh_s1 <= eh;
			dh_s1 <= sat48(WIDE_W'(eh) - WIDE_W'(prev_q));
		end
		if (adv.en2) begin
			h_s2 <= sat48(WIDE_W'(sat48(WIDE_W'(eh_s1) * HEIGHT_KP))
				+ WIDE_W'(sat48(WIDE_W'(dh_s1) * HEIGHT_KD)));
		end
		if (adv.en3) begin
			quot_s3 <= recip_prod[RECIP10_SH+QUOT_W-1:RECIP10_SH];
			neg_s3  <= h_s2[DATA_W-1];
		end
	end

endmodule

// ----- rtl/fapd_merge.sv -----
// Output stage: per-channel clamps, forward bias and the result register.
module fapd_merge import fapd_pkg::*; (
	input  logic               clk,
	input  fapd_adv_t          adv,
	input  logic [QUOT_W-1:0]  quot_s3,
	input  logic               neg_s3,
	input  q16_t               yaw_s3,
	input  q16_t               lat_s3,
	input  q16_t               fwd_s3,
	input  q16_t               forward_bias,
	output logic signed [18:0] vertical_rate_s4,
	output logic signed [21:0] yaw_rate_s4,
	output logic signed [16:0] lateral_speed_s4,
	output q16_t               forward_speed_s4
);

	logic [17:0]        vmag;
	logic signed [18:0] vert;
	logic signed [21:0] yaw;
	logic signed [16:0] lat;
	q16_t               fwd;

	always_comb begin
		vmag = (quot_s3 >= QUOT_W'(VERT_LIM)) ? VERT_LIM : quot_s3[17:0];
		vert = neg_s3 ? (19'sd0 - signed'({1'b0, vmag})) : signed'({1'b0, vmag});

		if (yaw_s3 > YAW_LIM) begin
			yaw = YAW_LIM[21:0];
		end else if (yaw_s3 < -YAW_LIM) begin
			yaw = 22'(-YAW_LIM);
		end else begin
			yaw = yaw_s3[21:0];
		end

		if (lat_s3 > LAT_LIM) begin
			lat = LAT_LIM[16:0];
		end else if (lat_s3 < -LAT_LIM) begin
			lat = 17'(-LAT_LIM);
		end else begin
			lat = lat_s3[16:0];
		end

		if (fwd_s3 > FWD_LIM) begin
			fwd = FWD_LIM;
		end else if (fwd_s3 < -FWD_LIM) begin
			fwd = -FWD_LIM;
		end else begin
			fwd = sat48(WIDE_W'(fwd_s3) + WIDE_W'(forward_bias));
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en4) begin
			vertical_rate_s4 <= vert;
			yaw_rate_s4      <= yaw;
			lateral_speed_s4 <= lat;
			forward_speed_s4 <= fwd;
		end
	end

endmodule

// ----- rtl/four_axis_pd_saturating_control.sv -----
// Top level of the four-axis PD controller with output saturation.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | height_target, height_measured, yaw_error,
//           |           |                   | lateral_error, forward_error (32b each)
//  m_*      | out       | m_tvalid/m_tready | vertical_rate, yaw_rate, lateral_speed,
//           |           |                   | forward_speed
//  cfg_*    | in        | cfg_we            | register index, 32-bit value
//
// One transaction per cycle in and one per cycle out while m_tready is high. From
// input acceptance to a valid result the stages are error/difference, gain
// multiply, PD sum, clamp and output register. Each stage advances when it is empty
// or the next one advances, so bubbles are squeezed out under output stall. Reset
// clears all valid bits, previous errors and gains to their initial values.
module four_axis_pd_saturating_control import fapd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] height_target, [63:32] height_measured, [95:64] yaw_error,
	// [127:96] lateral_error, [159:128] forward_error
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [18:0] vertical_rate, [40:19] yaw_rate, [57:41] lateral_speed,
	// [89:58] forward_speed, [95:90] zero
	output logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata
);

	q16_t yaw_gain_p_q;
	q16_t yaw_gain_d_q;
	q16_t lat_gain_p_q;
	q16_t lat_gain_d_q;
	q16_t fwd_gain_p_q;
	q16_t fwd_gain_d_q;
	q16_t fwd_bias_q;

	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	fapd_adv_t adv;
	logic      take;

	logic [QUOT_W-1:0]  quot_s3;
	logic               neg_s3;
	q16_t               yaw_s3;
	q16_t               lat_s3;
	q16_t               fwd_s3;
	logic signed [18:0] vertical_rate_s4;
	logic signed [21:0] yaw_rate_s4;
	logic signed [16:0] lateral_speed_s4;
	q16_t               forward_speed_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_gain_p_q <= '0;
			yaw_gain_d_q <= '0;
			lat_gain_p_q <= '0;
			lat_gain_d_q <= '0;
			fwd_gain_p_q <= FWD_GAIN_P_RST;
			fwd_gain_d_q <= FWD_GAIN_D_RST;
			fwd_bias_q   <= '0;
		end else if (cfg_we) begin
			case (fapd_reg_t'(cfg_addr))
				REG_YAW_P:    yaw_gain_p_q <= cfg_wdata;
				REG_YAW_D:    yaw_gain_d_q <= cfg_wdata;
				REG_LAT_P:    lat_gain_p_q <= cfg_wdata;
				REG_LAT_D:    lat_gain_d_q <= cfg_wdata;
				REG_FWD_P:    fwd_gain_p_q <= cfg_wdata;
				REG_FWD_D:    fwd_gain_d_q <= cfg_wdata;
				REG_FWD_BIAS: fwd_bias_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		adv.en4 = !valid_s4 || m_tready;
		adv.en3 = !valid_s3 || adv.en4;
		adv.en2 = !valid_s2 || adv.en3;
		adv.en1 = !valid_s1 || adv.en2;
	end

	assign s_tready = adv.en1;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv.en1) valid_s1 <= s_tvalid;
			if (adv.en2) valid_s2 <= valid_s1;
			if (adv.en3) valid_s3 <= valid_s2;
			if (adv.en4) valid_s4 <= valid_s3;
		end
	end

	fapd_height u_height (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (take),
		.target   (s_tdata[31:0]),
		.measured (s_tdata[63:32]),
		.quot_s3  (quot_s3),
		.neg_s3   (neg_s3)
	);

	fapd_lane u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.take   (take),
		.err    (s_tdata[95:64]),
		.gain_p (yaw_gain_p_q),
		.gain_d (yaw_gain_d_q),
		.pd_s3  (yaw_s3)
	);

	fapd_lane u_lat (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.take   (take),
		.err    (s_tdata[127:96]),
		.gain_p (lat_gain_p_q),
		.gain_d (lat_gain_d_q),
		.pd_s3  (lat_s3)
	);

	fapd_lane u_fwd (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.take   (take),
		.err    (s_tdata[159:128]),
		.gain_p (fwd_gain_p_q),
		.gain_d (fwd_gain_d_q),
		.pd_s3  (fwd_s3)
	);

	fapd_merge u_merge (
		.clk              (clk),
		.adv              (adv),
		.quot_s3          (quot_s3),
		.neg_s3           (neg_s3),
		.yaw_s3           (yaw_s3),
		.lat_s3           (lat_s3),
		.fwd_s3           (fwd_s3),
		.forward_bias     (fwd_bias_q),
		.vertical_rate_s4 (vertical_rate_s4),
		.yaw_rate_s4      (yaw_rate_s4),
		.lateral_speed_s4 (lateral_speed_s4),
		.forward_speed_s4 (forward_speed_s4)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = {6'd0, forward_speed_s4, lateral_speed_s4, yaw_rate_s4,
		vertical_rate_s4};

`ifndef SYNTH
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2 || !valid_s3 || !valid_s4) |-> s_tready)
		else $error("pipeline has a bubble but input is stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted transaction did not enter stage one");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s4) |-> $past(valid_s3))
		else $error("result appeared without a stage three transaction");

	a_vert_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (vertical_rate_s4 <= 19'sd131072 && vertical_rate_s4 >= -19'sd131072))
		else $error("vertical rate out of range");
`endif

endmodule

// ----- test/four_axis_pd_saturating_control_chk.sv -----
`timescale 1ns / 100ps
// Checker for the four-axis PD controller: watches all channels, predicts each command and compares.
module four_axis_pd_saturating_control_chk import fapd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata,
	output int           fail_count,
	output int           outstanding
);

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [16:0] vy;
		logic signed [21:0] wy;
		logic signed [18:0] vz;
	} command_t;

	command_t command_q[$];
	int       command_idx;

	longint yaw_kp, yaw_kd, lat_kp, lat_kd, fwd_kp, fwd_kd, fwd_offset;
	longint hgt_last, yaw_last, lat_last, fwd_last;

	function automatic longint clip32(input longint v);
		if (v > longint'(S32_MAX)) begin
			return longint'(S32_MAX);
		end else if (v < longint'(S32_MIN)) begin
			return longint'(S32_MIN);
		end
		return v;
	endfunction

	function automatic longint qprod(input longint a, input longint b);
		return clip32((a * b) >>> 16);
	endfunction

	function automatic longint limit_sym(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic command_t control_law(input logic [159:0] d);
		longint   tgt, meas, ey, el, ef, eh, h, f;
		command_t c;
		tgt  = longint'(q16_t'(d[31:0]));
		meas = longint'(q16_t'(d[63:32]));
		ey   = longint'(q16_t'(d[95:64]));
		el   = longint'(q16_t'(d[127:96]));
		ef   = longint'(q16_t'(d[159:128]));

		eh = clip32(tgt - meas);
		h = clip32(clip32(5 * eh) + clip32(30 * clip32(eh - hgt_last)));
		hgt_last = eh;
		h = h / 10;
		if (h >= longint'(VERT_LIM)) begin
			h = longint'(VERT_LIM);
		end else if (h <= -longint'(VERT_LIM)) begin
			h = -longint'(VERT_LIM);
		end
		c.vz = h[18:0];

		f = clip32(qprod(yaw_kp, ey) + qprod(yaw_kd, clip32(ey - yaw_last)));
		yaw_last = ey;
		f = limit_sym(f, longint'(YAW_LIM));
		c.wy = f[21:0];

		f = clip32(qprod(lat_kp, el) + qprod(lat_kd, clip32(el - lat_last)));
		lat_last = el;
		f = limit_sym(f, longint'(LAT_LIM));
		c.vy = f[16:0];

		f = clip32(qprod(fwd_kp, ef) + qprod(fwd_kd, clip32(ef - fwd_last)));
		fwd_last = ef;
		if (f > longint'(FWD_LIM)) begin
			f = longint'(FWD_LIM);
		end else if (f < -longint'(FWD_LIM)) begin
			f = -longint'(FWD_LIM);
		end else begin
			f = clip32(f + fwd_offset);
		end
		c.vx = f[31:0];
		return c;
	endfunction

	task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on command %0d, %s: got %h want %h", command_idx, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		outstanding = 0;
		command_idx = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_kp = 0;
			yaw_kd = 0;
			lat_kp = 0;
			lat_kd = 0;
			fwd_kp = longint'(FWD_GAIN_P_RST);
			fwd_kd = longint'(FWD_GAIN_D_RST);
			fwd_offset = 0;
			hgt_last = 0;
			yaw_last = 0;
			lat_last = 0;
			fwd_last = 0;
			command_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_YAW_P:    yaw_kp = longint'(q16_t'(cfg_wdata));
					REG_YAW_D:    yaw_kd = longint'(q16_t'(cfg_wdata));
					REG_LAT_P:    lat_kp = longint'(q16_t'(cfg_wdata));
					REG_LAT_D:    lat_kd = longint'(q16_t'(cfg_wdata));
					REG_FWD_P:    fwd_kp = longint'(q16_t'(cfg_wdata));
					REG_FWD_D:    fwd_kd = longint'(q16_t'(cfg_wdata));
					REG_FWD_BIAS: fwd_offset = longint'(q16_t'(cfg_wdata));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				command_q.push_back(control_law(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (command_q.size() == 0) begin
					flag("unexpected command", m_tdata[31:0], '0);
				end else begin
					command_t want;
					want = command_q.pop_front();
					if (m_tdata[18:0] !== want.vz) begin
						flag("vertical_rate", 32'(m_tdata[18:0]), 32'(want.vz));
					end
					if (m_tdata[40:19] !== want.wy) begin
						flag("yaw_rate", 32'(m_tdata[40:19]), 32'(want.wy));
					end
					if (m_tdata[57:41] !== want.vy) begin
						flag("lateral_speed", 32'(m_tdata[57:41]), 32'(want.vy));
					end
					if (m_tdata[89:58] !== want.vx) begin
						flag("forward_speed", m_tdata[89:58], want.vx);
					end
					if (m_tdata[95:90] !== 6'd0) begin
						flag("padding", 32'(m_tdata[95:90]), '0);
					end
				end
				command_idx++;
			end
			outstanding = command_q.size();
		end
	end

endmodule

// ----- test/four_axis_pd_saturating_control_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the four-axis PD controller: drives ticks and gain settings, gives the verdict.
module four_axis_pd_saturating_control_tb import fapd_pkg::*;;

	localparam logic [2:0] REG_SPARE   = 3'd7;
	localparam int         CYCLE_LIMIT = 200000;
	localparam q16_t       Q_ONE       = 32'sd65536;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [31:0]  cfg_wdata;

	int   fail_count;
	int   outstanding;
	int   cycles;
	int   stall_left;
	bit   quiet;
	q16_t gains [7];
	q16_t last_in [5];

	four_axis_pd_saturating_control u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	four_axis_pd_saturating_control_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL four_axis_pd_saturating_control");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic q16_t pick_q16();
		q16_t v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = S32_MAX;
					1: v = S32_MIN;
					2: v = '0;
					3: v = -32'sd1;
					default: v = 32'sd1;
				endcase
			end
			1, 2, 3: v = $urandom;
			default: v = $urandom_range(0, 524288) - 262144;
		endcase
		return v;
	endfunction

	task automatic push_tick(input q16_t tgt, input q16_t meas, input q16_t ey, input q16_t el,
			input q16_t ef);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ef, el, ey, meas, tgt};
		last_in[0] = tgt;
		last_in[1] = meas;
		last_in[2] = ey;
		last_in[3] = el;
		last_in[4] = ef;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// keep a field now and then so the derivative term sees steady errors
	task automatic random_ticks(input int n);
		q16_t f [5];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 5; k++) begin
				f[k] = ($urandom_range(0, 3) == 0) ? last_in[k] : pick_q16();
			end
			push_tick(f[0], f[1], f[2], f[3], f[4]);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input q16_t v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic load_gains();
		put_reg(REG_YAW_P, gains[REG_YAW_P]);
		put_reg(REG_YAW_D, gains[REG_YAW_D]);
		put_reg(REG_LAT_P, gains[REG_LAT_P]);
		put_reg(REG_LAT_D, gains[REG_LAT_D]);
		put_reg(REG_FWD_P, gains[REG_FWD_P]);
		put_reg(REG_FWD_D, gains[REG_FWD_D]);
		put_reg(REG_FWD_BIAS, gains[REG_FWD_BIAS]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cycles = 0;
		stall_left = 0;
		quiet = 1'b0;
		for (int k = 0; k < 5; k++) last_in[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: field extremes, saturating height error, height clamp edge
		push_tick('0, '0, '0, '0, '0);
		push_tick(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
		push_tick(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
		push_tick(S32_MAX, S32_MIN, '0, S32_MAX, S32_MIN);
		push_tick(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX);
		push_tick(4 * Q_ONE, '0, '0, '0, '0);
		push_tick(4 * Q_ONE, '0, '0, '0, '0);
		push_tick('0, 32'sd3, '0, '0, 32'sd491520);
		push_tick('0, 32'sd3, '0, '0, 32'sd491520);
		push_tick(Q_ONE, '0, '0, '0, -32'sd589824);
		push_tick(Q_ONE, '0, '0, '0, -32'sd589824);
		drain();

		// unit proportional gains: channel limits exactly, then one past them
		gains[REG_YAW_P] = Q_ONE;
		gains[REG_YAW_D] = 32'sd32768;
		gains[REG_LAT_P] = Q_ONE;
		gains[REG_LAT_D] = 32'sd16384;
		gains[REG_FWD_P] = Q_ONE;
		gains[REG_FWD_D] = 32'sd8192;
		gains[REG_FWD_BIAS] = 32'sd6554;
		load_gains();
		push_tick('0, '0, YAW_LIM, LAT_LIM, FWD_LIM);
		push_tick('0, '0, YAW_LIM, LAT_LIM, FWD_LIM);
		push_tick('0, '0, -YAW_LIM, -LAT_LIM, -FWD_LIM);
		push_tick('0, '0, -YAW_LIM, -LAT_LIM, -FWD_LIM);
		push_tick('0, '0, YAW_LIM + 1, LAT_LIM + 1, FWD_LIM + 1);
		push_tick('0, '0, YAW_LIM + 1, LAT_LIM + 1, FWD_LIM + 1);
		push_tick('0, '0, -YAW_LIM - 1, -LAT_LIM - 1, -FWD_LIM - 1);
		push_tick('0, '0, -YAW_LIM - 1, -LAT_LIM - 1, -FWD_LIM - 1);
		random_ticks(80);
		drain();

		for (int k = 0; k < 7; k++) gains[k] = S32_MAX;
		load_gains();
		random_ticks(60);
		drain();

		for (int k = 0; k < 7; k++) gains[k] = S32_MIN;
		load_gains();
		random_ticks(60);
		drain();

		for (int k = 0; k < 7; k++) gains[k] = '0;
		load_gains();
		random_ticks(40);
		drain();

		for (int k = 0; k < 7; k++) gains[k] = $urandom;
		put_reg(REG_SPARE, $urandom);
		load_gains();
		random_ticks(80);
		drain();

		for (int k = 0; k < 6; k++) gains[k] = $urandom_range(0, 524288) - 262144;
		gains[REG_FWD_BIAS] = pick_q16();
		load_gains();
		random_ticks(100);
		quiet = 1'b1;
		random_ticks(80);
		drain();

		if (fail_count == 0) begin
			$display("PASS four_axis_pd_saturating_control");
		end else begin
			$display("FAIL four_axis_pd_saturating_control");
		end
		$finish;
	end

endmodule
